### sv/gmde_pkg.sv
`timescale 1ns / 1ps

package gmde_pkg;

    typedef logic [4:0] dp_op_t;

    localparam dp_op_t OP_NOP        = 5'd0;
    localparam dp_op_t OP_DIV_STEP   = 5'd1;
    localparam dp_op_t OP_SQRT_INIT  = 5'd2;
    localparam dp_op_t OP_SQRT_STEP  = 5'd3;
    localparam dp_op_t OP_AMP_MUL0   = 5'd4;
    localparam dp_op_t OP_AMP_MUL1   = 5'd5;
    localparam dp_op_t OP_AMP_MUL2   = 5'd6;
    localparam dp_op_t OP_AMP_WRITE  = 5'd7;
    localparam dp_op_t OP_XN_MUL     = 5'd8;
    localparam dp_op_t OP_XN_SET     = 5'd9;
    localparam dp_op_t OP_READ       = 5'd10;
    localparam dp_op_t OP_Z_MUL      = 5'd11;
    localparam dp_op_t OP_ZS_MUL     = 5'd12;
    localparam dp_op_t OP_T_SET      = 5'd13;
    localparam dp_op_t OP_TAY_MUL    = 5'd14;
    localparam dp_op_t OP_TAY_DIV    = 5'd15;
    localparam dp_op_t OP_TAY_UPD    = 5'd16;
    localparam dp_op_t OP_E_MUL      = 5'd17;
    localparam dp_op_t OP_TERM_MUL   = 5'd18;
    localparam dp_op_t OP_ACC        = 5'd19;
    localparam dp_op_t OP_RES_MUL0   = 5'd20;
    localparam dp_op_t OP_RES_MUL1   = 5'd21;
    localparam dp_op_t OP_RES_OUT    = 5'd22;

    localparam logic [1:0] REG_MIN_OFFSET = 2'd0;
    localparam logic [1:0] REG_SCALE      = 2'd1;
    localparam logic [1:0] REG_COUNT      = 2'd2;

    localparam logic [22:0] KINV       = 23'd6693133;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [6:0]  EXP_K_MAX  = 7'd22;
    localparam logic [3:0]  TAY_TERMS  = 4'd13;
    localparam logic [6:0]  DIV_STEPS  = 7'd65;
    localparam logic [6:0]  SQRT_STEPS = 7'd32;
    localparam logic [31:0] SCALE_RST  = 32'h0100_0000;

    typedef struct packed {
        dp_op_t     op;
        logic       capture;
        logic       first;
        logic [3:0] tn;
    } dp_cmd_t;

    typedef struct packed {
        logic comp_last;
        logic comp_none;
        logic out_free;
    } dp_stat_t;

    // exp(-k) in q.30 by repeated rounded multiply with exp(-1)
    function automatic logic [30:0] exp_int_calc(input int k);
        longint unsigned p;
        p = 64'd1073741824;
        for (int i = 0; i < k; i++) begin
            p = (p * 64'd395007542 + 64'd536870912) >> 30;
        end
        return 31'(p);
    endfunction

endpackage

### sv/gmde_ctrl.sv
`timescale 1ns / 1ps

module gmde_ctrl #(
    parameter int MAX_COMPONENTS = 64,
    parameter int CW = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               item_eval,
    output logic               s_tready,
    output gmde_pkg::dp_cmd_t  cmd,
    output logic [CW-1:0]      comp,
    input  gmde_pkg::dp_stat_t stat
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DIV    = 5'd1;
    localparam logic [4:0] ST_SQI    = 5'd2;
    localparam logic [4:0] ST_SQRT   = 5'd3;
    localparam logic [4:0] ST_AMP0   = 5'd4;
    localparam logic [4:0] ST_AMP1   = 5'd5;
    localparam logic [4:0] ST_AMP2   = 5'd6;
    localparam logic [4:0] ST_AMPW   = 5'd7;
    localparam logic [4:0] ST_XN0    = 5'd8;
    localparam logic [4:0] ST_XN1    = 5'd9;
    localparam logic [4:0] ST_READ   = 5'd10;
    localparam logic [4:0] ST_ZMUL   = 5'd11;
    localparam logic [4:0] ST_ZSMUL  = 5'd12;
    localparam logic [4:0] ST_TSET   = 5'd13;
    localparam logic [4:0] ST_TMUL   = 5'd14;
    localparam logic [4:0] ST_TDIV   = 5'd15;
    localparam logic [4:0] ST_TUPD   = 5'd16;
    localparam logic [4:0] ST_EMUL   = 5'd17;
    localparam logic [4:0] ST_TERM   = 5'd18;
    localparam logic [4:0] ST_ACC    = 5'd19;
    localparam logic [4:0] ST_RES0   = 5'd20;
    localparam logic [4:0] ST_RES1   = 5'd21;
    localparam logic [4:0] ST_RESOUT = 5'd22;

    logic [4:0]    state_reg, state_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [CW-1:0] comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign comp     = comp_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.first  = (cnt_reg == 7'd0);
        cmd.tn     = cnt_reg[3:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    comp_next   = '0;
                    state_next  = item_eval ? ST_XN0 : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op = gmde_pkg::OP_DIV_STEP;
                if (cnt_reg == gmde_pkg::DIV_STEPS - 7'd1) begin
                    cnt_next   = '0;
                    state_next = ST_SQI;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_SQI: begin
                cmd.op     = gmde_pkg::OP_SQRT_INIT;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = gmde_pkg::OP_SQRT_STEP;
                if (cnt_reg == gmde_pkg::SQRT_STEPS - 7'd1) begin
                    cnt_next   = '0;
                    state_next = ST_AMP0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_AMP0: begin
                cmd.op     = gmde_pkg::OP_AMP_MUL0;
                state_next = ST_AMP1;
            end
            ST_AMP1: begin
                cmd.op     = gmde_pkg::OP_AMP_MUL1;
                state_next = ST_AMP2;
            end
            ST_AMP2: begin
                cmd.op     = gmde_pkg::OP_AMP_MUL2;
                state_next = ST_AMPW;
            end
            ST_AMPW: begin
                cmd.op     = gmde_pkg::OP_AMP_WRITE;
                state_next = ST_IDLE;
            end
            ST_XN0: begin
                cmd.op     = gmde_pkg::OP_XN_MUL;
                state_next = ST_XN1;
            end
            ST_XN1: begin
                cmd.op     = gmde_pkg::OP_XN_SET;
                state_next = stat.comp_none ? ST_RES0 : ST_READ;
            end
            ST_READ: begin
                cmd.op     = gmde_pkg::OP_READ;
                state_next = ST_ZMUL;
            end
            ST_ZMUL: begin
                cmd.op     = gmde_pkg::OP_Z_MUL;
                state_next = ST_ZSMUL;
            end
            ST_ZSMUL: begin
                cmd.op     = gmde_pkg::OP_ZS_MUL;
                state_next = ST_TSET;
            end
            ST_TSET: begin
                cmd.op     = gmde_pkg::OP_T_SET;
                cnt_next   = 7'd1;
                state_next = ST_TMUL;
            end
            ST_TMUL: begin
                cmd.op     = gmde_pkg::OP_TAY_MUL;
                state_next = ST_TDIV;
            end
            ST_TDIV: begin
                cmd.op     = gmde_pkg::OP_TAY_DIV;
                state_next = ST_TUPD;
            end
            ST_TUPD: begin
                cmd.op = gmde_pkg::OP_TAY_UPD;
                if (cnt_reg[3:0] == gmde_pkg::TAY_TERMS) begin
                    cnt_next   = '0;
                    state_next = ST_EMUL;
                end else begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = ST_TMUL;
                end
            end
            ST_EMUL: begin
                cmd.op     = gmde_pkg::OP_E_MUL;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.op     = gmde_pkg::OP_TERM_MUL;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = gmde_pkg::OP_ACC;
                if (stat.comp_last) begin
                    state_next = ST_RES0;
                end else begin
                    comp_next  = comp_reg + CW'(1);
                    state_next = ST_READ;
                end
            end
            ST_RES0: begin
                cmd.op     = gmde_pkg::OP_RES_MUL0;
                state_next = ST_RES1;
            end
            ST_RES1: begin
                cmd.op     = gmde_pkg::OP_RES_MUL1;
                state_next = ST_RESOUT;
            end
            ST_RESOUT: begin
                cmd.op = gmde_pkg::OP_RES_OUT;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/gmde_dp.sv
`timescale 1ns / 1ps

module gmde_dp #(
    parameter int MAX_COMPONENTS = 64,
    parameter int CW = 7,
    parameter int AW = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [135:0]       s_tdata,
    input  logic               s_tlast,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               cfg_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast,
    input  gmde_pkg::dp_cmd_t  cmd,
    input  logic [CW-1:0]      comp,
    output gmde_pkg::dp_stat_t stat
);

    // configuration
    logic [31:0] min_reg, scale_reg;
    logic [6:0]  count_reg;

    // captured word
    logic [5:0]  index_reg;
    logic [31:0] mean_in_reg, var_reg, weight_reg, sample_reg;
    logic        last_reg;

    // working registers
    logic [65:0] prod_reg, tmp_reg;
    logic [33:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] root_reg, inv_reg;
    logic [7:0]  hi8_reg;
    logic [55:0] xn_reg;
    logic        kill_reg;
    logic [30:0] ek_reg, term_reg;
    logic [29:0] r_reg, x_reg;
    logic signed [33:0] sum_reg;
    logic [47:0] acc_reg;

    // component table
    logic [95:0]               mem [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] valid_reg;
    logic [95:0]               rd_word_reg;
    logic                      rd_valid_reg;

    logic        m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [31:0] m_tdata_reg;

    logic [30:0] exp_tbl [32];
    logic [32:0] recip_tbl [16];

    for (genvar g = 0; g < 32; g++) begin : g_exp
        localparam logic [30:0] EV = (g < 22) ? gmde_pkg::exp_int_calc(g) : 31'd0;
        assign exp_tbl[g] = EV;
    end

    // ceil(2^32 / n)
    for (genvar g = 0; g < 16; g++) begin : g_recip
        localparam longint unsigned DV = (g == 0) ? 1 : g;
        localparam logic [32:0] RV = (g == 0) ? 33'd0
                                   : 33'((64'd4294967296 + DV - 64'd1) / DV);
        assign recip_tbl[g] = RV;
    end

    logic        out_free, out_load, mem_we;
    logic [32:0] mul_a, mul_b;
    logic        mul_en;

    logic signed [32:0] diff;
    logic        neg;
    logic [32:0] mag;
    logic [64:0] xn_full;
    logic [54:0] xm;
    logic [55:0] xn_val;

    logic [31:0] mean_q, inv_q, amp_q;
    logic [56:0] d_val, dm;

    logic [32:0] div_s, sub_v;
    logic        div_ge;
    logic [35:0] sq_s, sq_t;
    logic        sq_ge;

    logic [31:0] inv_val;
    logic [63:0] amp_sum;
    logic [31:0] amp_val;

    logic [52:0] t_val;
    logic [6:0]  k_val;
    logic        k_big;

    logic [30:0] q_est, q_val;
    logic [34:0] qn;

    logic [32:0] ef;
    logic [44:0] term_val;
    logic [48:0] acc_sum;

    logic [79:0] res_full;
    logic [45:0] res_val;

    logic        count_big;
    logic [31:0] n_eff;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (cmd.op == gmde_pkg::OP_RES_OUT) && out_free;
    assign mem_we    = (cmd.op == gmde_pkg::OP_AMP_WRITE)
                     && (32'(index_reg) < 32'(MAX_COMPONENTS));

    assign count_big      = 32'(count_reg) > 32'(MAX_COMPONENTS);
    assign n_eff          = count_big ? 32'(MAX_COMPONENTS) : 32'(count_reg);
    assign stat.comp_none = (n_eff == 32'd0);
    assign stat.comp_last = (32'(comp) + 32'd1) >= n_eff;
    assign stat.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        diff    = $signed({sample_reg[31], sample_reg}) - $signed({min_reg[31], min_reg});
        neg     = diff[32];
        mag     = neg ? 33'(-diff) : 33'(diff);
        xn_full = {1'b0, prod_reg[63:0]} + (mag[32] ? {1'b0, scale_reg, 32'd0} : 65'd0);
        xm      = xn_full[64:10];
        xn_val  = neg ? (56'd0 - {1'b0, xm}) : {1'b0, xm};

        mean_q = rd_valid_reg ? rd_word_reg[31:0]  : 32'd0;
        inv_q  = rd_valid_reg ? rd_word_reg[63:32] : 32'd0;
        amp_q  = rd_valid_reg ? rd_word_reg[95:64] : 32'd0;
        d_val  = {xn_reg[55], xn_reg} - {{25{mean_q[31]}}, mean_q};
        dm     = d_val[56] ? (57'd0 - d_val) : d_val;

        div_s  = {rem_reg[31:0], cmd.first};
        div_ge = div_s >= {1'b0, var_reg};
        sub_v  = div_s - {1'b0, var_reg};

        sq_s  = {rem_reg, quo_reg[63:62]};
        sq_t  = {2'b00, root_reg, 2'b01};
        sq_ge = sq_s >= sq_t;

        inv_val = (var_reg < 32'd2) ? 32'hFFFF_FFFF : root_reg;
        amp_sum = tmp_reg[63:0] + {prod_reg[31:0], 32'd0};
        amp_val = (amp_sum[63:62] != 2'b00) ? 32'hFFFF_FFFF : amp_sum[61:30];

        t_val = prod_reg[53:1];
        k_val = t_val[52:46];
        k_big = k_val >= gmde_pkg::EXP_K_MAX;

        q_est = prod_reg[62:32];
        qn    = 35'(q_est) * 35'(cmd.tn);
        q_val = (qn > 35'(x_reg)) ? (q_est - 31'd1) : q_est;

        ef       = sum_reg[33] ? 33'd0 : 33'(sum_reg[32:0]);
        term_val = kill_reg ? 45'd0 : prod_reg[65:21];
        acc_sum  = {1'b0, acc_reg} + 49'(term_val);

        res_full = {14'd0, tmp_reg} + {prod_reg[46:0], 33'd0};
        res_val  = res_full[79:34];
    end

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            gmde_pkg::OP_AMP_MUL0: begin
                mul_a = {1'b0, weight_reg};
                mul_b = {1'b0, inv_val};
            end
            gmde_pkg::OP_AMP_MUL1: begin
                mul_a = {1'b0, prod_reg[55:24]};
                mul_b = 33'(gmde_pkg::KINV);
            end
            gmde_pkg::OP_AMP_MUL2: begin
                mul_a = 33'(hi8_reg);
                mul_b = 33'(gmde_pkg::KINV);
            end
            gmde_pkg::OP_XN_MUL: begin
                mul_a = {1'b0, mag[31:0]};
                mul_b = {1'b0, scale_reg};
            end
            gmde_pkg::OP_Z_MUL: begin
                mul_a = 33'(dm[33:4]);
                mul_b = {1'b0, inv_q};
            end
            gmde_pkg::OP_ZS_MUL: begin
                mul_a = 33'(prod_reg[45:19]);
                mul_b = 33'(prod_reg[45:19]);
            end
            gmde_pkg::OP_TAY_MUL: begin
                mul_a = 33'(term_reg);
                mul_b = 33'(r_reg);
            end
            gmde_pkg::OP_TAY_DIV: begin
                mul_a = 33'(prod_reg[59:30]);
                mul_b = recip_tbl[cmd.tn];
            end
            gmde_pkg::OP_E_MUL: begin
                mul_a = 33'(ek_reg);
                mul_b = ef;
            end
            gmde_pkg::OP_TERM_MUL: begin
                mul_a = {1'b0, amp_q};
                mul_b = prod_reg[62:30];
            end
            gmde_pkg::OP_RES_MUL0: begin
                mul_a = acc_reg[32:0];
                mul_b = {1'b0, scale_reg};
            end
            gmde_pkg::OP_RES_MUL1: begin
                mul_a = 33'(acc_reg[47:33]);
                mul_b = {1'b0, scale_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '0;
            scale_reg    <= gmde_pkg::SCALE_RST;
            count_reg    <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    gmde_pkg::REG_MIN_OFFSET: min_reg   <= cfg_data;
                    gmde_pkg::REG_SCALE:      scale_reg <= cfg_data;
                    gmde_pkg::REG_COUNT:      count_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (mem_we) begin
                valid_reg[AW'(index_reg)] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(index_reg)] <= {amp_val, inv_reg, mean_in_reg};
        end
        if (cmd.op == gmde_pkg::OP_READ) begin
            rd_word_reg  <= mem[comp[AW-1:0]];
            rd_valid_reg <= valid_reg[comp[AW-1:0]];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.capture) begin
            index_reg   <= s_tdata[5:0];
            mean_in_reg <= s_tdata[37:6];
            var_reg     <= s_tdata[69:38];
            weight_reg  <= s_tdata[101:70];
            sample_reg  <= s_tdata[133:102];
            last_reg    <= s_tlast;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        if (out_load) begin
            m_tdata_reg <= (res_val[45:32] != 14'd0) ? 32'hFFFF_FFFF : res_val[31:0];
            m_tuser_reg <= (res_val[45:32] != 14'd0);
            m_tlast_reg <= last_reg;
        end
        case (cmd.op)
            gmde_pkg::OP_DIV_STEP: begin
                rem_reg <= 34'(div_ge ? sub_v[31:0] : div_s[31:0]);
                quo_reg <= {quo_reg[62:0], div_ge};
            end
            gmde_pkg::OP_SQRT_INIT: begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            gmde_pkg::OP_SQRT_STEP: begin
                rem_reg  <= sq_ge ? 34'(sq_s - sq_t) : sq_s[33:0];
                root_reg <= {root_reg[30:0], sq_ge};
                quo_reg  <= {quo_reg[61:0], 2'b00};
            end
            gmde_pkg::OP_AMP_MUL0: begin
                inv_reg <= inv_val;
            end
            gmde_pkg::OP_AMP_MUL1: begin
                hi8_reg <= prod_reg[63:56];
            end
            gmde_pkg::OP_AMP_MUL2: begin
                tmp_reg <= prod_reg;
            end
            gmde_pkg::OP_XN_SET: begin
                xn_reg  <= xn_val;
                acc_reg <= '0;
            end
            gmde_pkg::OP_Z_MUL: begin
                kill_reg <= (dm[56:34] != 23'd0);
            end
            gmde_pkg::OP_ZS_MUL: begin
                kill_reg <= kill_reg || (prod_reg[65:46] != 20'd0);
            end
            gmde_pkg::OP_T_SET: begin
                kill_reg <= kill_reg || k_big;
                ek_reg   <= k_big ? 31'd0 : exp_tbl[k_val[4:0]];
                r_reg    <= t_val[45:16];
                term_reg <= gmde_pkg::ONE_Q30;
                sum_reg  <= 34'(gmde_pkg::ONE_Q30);
            end
            gmde_pkg::OP_TAY_DIV: begin
                x_reg <= prod_reg[59:30];
            end
            gmde_pkg::OP_TAY_UPD: begin
                term_reg <= q_val;
                sum_reg  <= cmd.tn[0] ? (sum_reg - $signed(34'(q_val)))
                                      : (sum_reg + $signed(34'(q_val)));
            end
            gmde_pkg::OP_ACC: begin
                acc_reg <= acc_sum[48] ? 48'hFFFF_FFFF_FFFF : acc_sum[47:0];
            end
            gmde_pkg::OP_RES_MUL1: begin
                tmp_reg <= prod_reg;
            end
            default: ;
        endcase
    end

endmodule

### sv/gaussian_mixture_density_eval.sv
`timescale 1ns / 1ps

// Gaussian mixture density evaluator. Items are handled one at a time. A load word
// (tuser 0) runs a 65-step restoring divider and a 32-step square root that
// derive 1/sqrt(variance), then makes three passes through the shared 33x33
// multiplier for the amplitude. An evaluate word (tuser 1) sums N components:
// every component makes 30 passes through the one shared multiplier, including
// those of the 13-term exp series. The table resets to empty at once with no
// clearing pass; configuration is to be written by the user while the block is
// idle (the block does not enforce this), and a finished result waits in an
// output register while the next word is taken.
module gaussian_mixture_density_eval #(
    parameter int MAX_COMPONENTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // index, mean, variance, weight, sample, zero pad
    input  logic         s_tuser,  // op
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // density_value
    output logic         m_tuser,  // saturated
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW = $clog2(MAX_COMPONENTS + 1);
    localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    gmde_pkg::dp_cmd_t  cmd;
    gmde_pkg::dp_stat_t stat;
    logic [CW-1:0]      comp;

    gmde_ctrl #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .CW(CW)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .item_eval(s_tuser),
        .s_tready(s_tready),
        .cmd(cmd),
        .comp(comp),
        .stat(stat)
    );

    gmde_dp #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .CW(CW),
        .AW(AW)
    ) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg_ready(cfg_ready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cmd(cmd),
        .comp(comp),
        .stat(stat)
    );

endmodule

### sv/gmde_check.sv
`timescale 1ns / 1ps

module gmde_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two cycles in a row");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
        else $error("saturated flag without clamped density");

endmodule

bind gaussian_mixture_density_eval gmde_check u_check (.*);

### bench/gaussian_mixture_density_checker.sv
`timescale 1ns / 1ps

module gaussian_mixture_density_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending,
    output int           densities_seen,
    output int           clamped_seen
);

    typedef struct packed {
        logic [31:0] density;
        logic        clamped;
        logic        batch_end;
    } density_t;

    density_t density_q[$];

    logic signed [31:0] min_off;
    logic [31:0]        scale_r;
    logic [6:0]         comp_cnt;
    logic signed [31:0] mean_tab [64];
    logic [31:0]        invdev_tab [64];
    logic [31:0]        amp_tab [64];

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] inv_deviation(input logic [31:0] v);
        logic [63:0] q, r, s;
        if (v < 2) return 32'hFFFF_FFFF;
        q = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, v};
        r = 64'hFFFF_FFFF_FFFF_FFFF % {32'd0, v};
        if (r == {32'd0, v} - 1) q = q + 1;
        s = root64(q);
        return s[31:0];
    endfunction

    function automatic logic [63:0] exp_frac(input logic [63:0] r);
        longint sum;
        logic [63:0] t;
        sum = 64'd1073741824;
        t = 64'd1073741824;
        for (int n = 1; n <= 13; n++) begin
            t = ((t * r) >> 30) / n;
            if (n % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
        end
        return sum < 0 ? 64'd0 : 64'(sum);
    endfunction

    function automatic logic [63:0] comp_term(input longint xn, input int c);
        longint d;
        logic [63:0] dm, z, zs, t, k, e, p;
        d = xn - longint'(mean_tab[c]);
        dm = d < 0 ? 64'(-d) : 64'(d);
        if (dm >= (64'd1 << 34)) return 0;
        z = (dm >> 4) * {32'd0, invdev_tab[c]};
        if (z >= (64'd1 << 46)) return 0;
        zs = z >> 19;
        t = (zs * zs) >> 1;
        k = t >> 46;
        if (k >= 22) return 0;
        p = 64'd1073741824;
        for (int i = 0; i < int'(k); i++) p = (p * 64'd395007542 + 64'd536870912) >> 30;
        e = (p * exp_frac((t >> 16) & 64'h3FFF_FFFF)) >> 30;
        return ({32'd0, amp_tab[c]} * e) >> 21;
    endfunction

    function automatic density_t eval_density(input logic [31:0] smp, input logic lst);
        density_t res;
        longint diff, xn;
        logic [63:0] mag, acc, a, b, sum;
        int n;
        diff = longint'(signed'(smp)) - longint'(min_off);
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        mag = (mag * {32'd0, scale_r}) >> 10;
        xn = diff < 0 ? -longint'(mag) : longint'(mag);
        n = comp_cnt > 64 ? 64 : comp_cnt;
        acc = 0;
        for (int c = 0; c < n; c++) begin
            acc = acc + comp_term(xn, c);
            if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
        end
        a = acc * {48'd0, scale_r[31:16]};
        b = acc * {48'd0, scale_r[15:0]};
        sum = (a >> 18) + (b >> 34) + ((((a & 64'h3FFFF) << 16) + (b & 64'h3_FFFF_FFFF)) >> 34);
        res.clamped = sum > 64'hFFFF_FFFF;
        res.density = res.clamped ? 32'hFFFF_FFFF : sum[31:0];
        res.batch_end = lst;
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [63:0] amp;
        logic [31:0] inv;
        int idx;
        density_t got;
        if (!aresetn) begin
            min_off <= 0;
            scale_r <= gmde_pkg::SCALE_RST;
            comp_cnt <= 0;
            for (int i = 0; i < 64; i++) begin
                mean_tab[i] = 0;
                invdev_tab[i] = 0;
                amp_tab[i] = 0;
            end
            density_q.delete();
            fail_count <= 0;
            densities_seen <= 0;
            clamped_seen <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gmde_pkg::REG_MIN_OFFSET: min_off <= cfg_data;
                    gmde_pkg::REG_SCALE: scale_r <= cfg_data;
                    gmde_pkg::REG_COUNT: comp_cnt <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    density_q.push_back(eval_density(s_tdata[133:102], s_tlast));
                end else begin
                    idx = int'(s_tdata[5:0]);
                    inv = inv_deviation(s_tdata[69:38]);
                    amp = (((({32'd0, s_tdata[101:70]} * {32'd0, inv}) >> 24)
                           * 64'd6693133) >> 30);
                    if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
                    mean_tab[idx] = s_tdata[37:6];
                    invdev_tab[idx] = inv;
                    amp_tab[idx] = amp[31:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser, m_tlast};
                densities_seen <= densities_seen + 1;
                if (m_tuser) clamped_seen <= clamped_seen + 1;
                if (density_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected density word %h", got);
                end else if (density_q[0] !== got) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("density mismatch: expected %h/%b/%b got %h/%b/%b",
                                 density_q[0].density, density_q[0].clamped,
                                 density_q[0].batch_end, m_tdata, m_tuser, m_tlast);
                    void'(density_q.pop_front());
                end else begin
                    void'(density_q.pop_front());
                end
            end
            pending <= density_q.size();
        end
    end

endmodule

### bench/gaussian_mixture_density_eval_tb.sv
`timescale 1ns / 1ps

module gaussian_mixture_density_eval_tb;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;  // index, mean, variance, weight, sample, zero pad
    logic         s_tuser;  // op
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;  // density_value
    logic         m_tuser;  // saturated
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count, pending, densities_seen, clamped_seen;
    int           cycles = 0;
    int           words_sent;
    bit           calm;

    gaussian_mixture_density_eval dut (.*);

    gaussian_mixture_density_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 20_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 32);
    end

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 32) @(posedge aclk);
    endtask

    task automatic send_word(input logic op, input logic [5:0] idx, input logic [31:0] mean,
                             input logic [31:0] var_q, input logic [31:0] wt,
                             input logic [31:0] smp, input logic lst);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tlast <= lst;
        s_tdata <= {2'b00, smp, wt, var_q, mean, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        words_sent++;
        @(posedge aclk);
    endtask

    task automatic load_comp(input logic [5:0] idx, input logic [31:0] mean,
                             input logic [31:0] var_q, input logic [31:0] wt);
        send_word(1'b0, idx, mean, var_q, wt, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic eval_at(input logic [31:0] smp, input logic lst);
        send_word(1'b1, 6'($urandom), $urandom, $urandom, $urandom, smp, lst);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_var();
        case ($urandom_range(3))
            0: return $urandom_range(1, 0);
            1: return $urandom_range(32'h0100_0000, 32'h0001_0000);
            2: return $urandom_range(32'h4000_0000, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h0;
            2: return $urandom;
            default: return $urandom_range(32'h8000_0000);
        endcase
    endfunction

    initial begin
        int n;
        logic [31:0] centers [8];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gmde_pkg::REG_MIN_OFFSET;
        cfg_data = '0;
        words_sent = 0;
        calm = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, reset registers
        eval_at(32'h0001_0000, 1'b1);
        drain();
        write_reg(gmde_pkg::REG_COUNT, 7'd3);
        write_reg(gmde_pkg::REG_SCALE, 32'h0100_0000);
        write_reg(gmde_pkg::REG_MIN_OFFSET, 32'h0);
        load_comp(6'd0, 32'h0, 32'h0, 32'h8000_0000);
        load_comp(6'd1, 32'h4000_0000, 32'h1, 32'hFFFF_FFFF);
        load_comp(6'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        load_comp(6'd63, 32'h7FFF_FFFF, 32'h0100_0000, 32'h4000_0000);
        eval_at(32'h0, 1'b0);
        eval_at(32'h7FFF_FFFF, 1'b1);
        eval_at(32'h8000_0000, 1'b0);
        eval_at(32'h0000_0010, 1'b1);
        drain();
        write_reg(gmde_pkg::REG_COUNT, 7'd127);
        write_reg(2'd3, 32'hFFFF_FFFF);
        eval_at(32'h0, 1'b1);
        eval_at(32'hFFFF_FFF0, 1'b0);
        drain();
        write_reg(gmde_pkg::REG_SCALE, 32'hFFFF_FFFF);
        write_reg(gmde_pkg::REG_MIN_OFFSET, 32'h8000_0000);
        eval_at(32'h7FFF_FFFF, 1'b1);
        eval_at(32'h8000_0000, 1'b0);
        drain();
        write_reg(gmde_pkg::REG_SCALE, 32'h0);
        write_reg(gmde_pkg::REG_MIN_OFFSET, 32'h7FFF_FFFF);
        eval_at(32'h0, 1'b1);
        drain();

        // random phases: small tables mostly, one full table
        for (int ph = 0; ph < 12; ph++) begin
            n = (ph == 5) ? 64 : $urandom_range(6, 1);
            write_reg(gmde_pkg::REG_COUNT, (ph == 7) ? 7'd65 : n[6:0]);
            write_reg(gmde_pkg::REG_SCALE, $urandom_range(3) == 0 ? $urandom
                                 : $urandom_range(32'h0400_0000, 32'h0040_0000));
            write_reg(gmde_pkg::REG_MIN_OFFSET, $urandom_range(3) == 0 ? $urandom
                                      : $urandom_range(32'h0010_0000) - 32'h0008_0000);
            calm = (ph == 3);
            for (int i = 0; i < 8; i++) centers[i] = $urandom;
            for (int i = 0; i < n; i++) begin
                centers[i % 8] = $urandom_range(32'h2000_0000) - 32'h1000_0000;
                load_comp(i[5:0], centers[i % 8], rand_var(), rand_weight());
            end
            for (int i = 0; i < ((ph == 5) ? 20 : 118); i++) begin
                if ($urandom_range(9) == 0)
                    load_comp(6'($urandom_range(63)), $urandom, rand_var(), rand_weight());
                else if ($urandom_range(3) == 0)
                    eval_at($urandom, 1'($urandom_range(1)));
                else
                    eval_at($urandom_range(32'h0008_0000) - 32'h0004_0000,
                            1'($urandom_range(1)));
                if (ph == 9 && i == 50) drain();
            end
            drain();
        end
        calm = 1'b0;

        $display("sent %0d words; checked %0d densities, %0d of them clamped",
                 words_sent, densities_seen, clamped_seen);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
